@@ hw/rtl/swae_pkg.sv @@
// Shared types, codes and helper functions for the sensor window average event unit.
package swae_pkg;

    // Width of a raw sample and of the temperature path.
    localparam int VALUE_W = 11;
    // Width of the unsigned light and humidity paths.
    localparam int UVAL_W  = 10;

    localparam logic [1:0] KIND_LIGHT  = 2'd0;
    localparam logic [1:0] KIND_TEMP   = 2'd1;
    localparam logic [1:0] KIND_HUM    = 2'd2;
    localparam logic [1:0] KIND_REPORT = 2'd3;

    localparam logic [1:0] EV_DEFAULT   = 2'd0;
    localparam logic [1:0] EV_TEMP_HIGH = 2'd1;
    localparam logic [1:0] EV_HUM_HIGH  = 2'd2;
    localparam logic [1:0] EV_LIGHT_LOW = 2'd3;

    localparam logic [1:0] CFG_TEMP_LIMIT  = 2'd0;
    localparam logic [1:0] CFG_HUM_LIMIT   = 2'd1;
    localparam logic [1:0] CFG_LIGHT_LIMIT = 2'd2;

    localparam logic signed [VALUE_W-1:0] TEMP_LIMIT_RST  = 11'sd255;
    localparam logic        [UVAL_W-1:0]  HUM_LIMIT_RST   = 10'd600;
    localparam logic        [UVAL_W-1:0]  LIGHT_LIMIT_RST = 10'd60;

    // Per-channel control for one cycle.
    typedef struct packed {
        logic push;
        logic latch;
    } t_chan_ctrl;

    // Saturate a signed sample into 0..1023.
    function automatic logic [UVAL_W-1:0] f_clamp_u10(logic signed [VALUE_W-1:0] v);
        logic [UVAL_W-1:0] res;
        if (v[VALUE_W-1]) begin
            res = '0;
        end else begin
            res = v[UVAL_W-1:0];
        end
        return res;
    endfunction

    // Priority event: hot first, then humid, then dark.
    function automatic logic [1:0] f_event(
        logic signed [VALUE_W-1:0] temp_avg,
        logic        [UVAL_W-1:0]  hum_avg,
        logic        [UVAL_W-1:0]  light_avg,
        logic signed [VALUE_W-1:0] temp_limit,
        logic        [UVAL_W-1:0]  hum_limit,
        logic        [UVAL_W-1:0]  light_limit
    );
        logic [1:0] ev;
        if (temp_avg > temp_limit) begin
            ev = EV_TEMP_HIGH;
        end else if (hum_avg > hum_limit) begin
            ev = EV_HUM_HIGH;
        end else if (light_avg < light_limit) begin
            ev = EV_LIGHT_LOW;
        end else begin
            ev = EV_DEFAULT;
        end
        return ev;
    endfunction

endpackage

@@ hw/rtl/sensor_window_average_event_unit.sv @@
// Top level of the sensor window average event unit: input stage, channels, result register.
// Accepts one transaction per clock. A transaction is captured in an input register and
// processed from there; a report's result is loaded into the result register, which drives
// o_out_valid. Samples never stall; a report waits in the input register only while the
// result register is full and not taken. Each channel keeps a registered sum of its ring,
// so a report costs one constant multiply.
module sensor_window_average_event_unit #(
    parameter int WINDOW = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  logic [1:0]   i_kind,
    input  logic signed [10:0] i_sample_value,
    input  logic         i_sample_ok,
    output logic         o_out_valid,
    input  logic         i_out_ready,
    output logic [1:0]   o_event_code,
    output logic signed [10:0] o_temp_average,
    output logic [9:0]   o_humidity_average,
    output logic [9:0]   o_light_average,
    input  logic         i_cfg_we,
    input  logic [1:0]   i_cfg_index,
    input  logic [10:0]  i_cfg_data
);
    import swae_pkg::*;

    logic                      r_in_valid;
    logic [1:0]                r_in_kind;
    logic signed [VALUE_W-1:0] r_in_value;
    logic                      r_in_ok;

    logic signed [VALUE_W-1:0] r_temp_limit;
    logic [UVAL_W-1:0]         r_hum_limit;
    logic [UVAL_W-1:0]         r_light_limit;

    logic                      r_out_valid;
    logic [1:0]                r_event;
    logic signed [VALUE_W-1:0] r_temp_avg;
    logic [UVAL_W-1:0]         r_hum_avg;
    logic [UVAL_W-1:0]         r_light_avg;

    logic       is_report;
    logic       advance;
    logic       load_out;
    t_chan_ctrl ctrl_light;
    t_chan_ctrl ctrl_temp;
    t_chan_ctrl ctrl_hum;
    logic [UVAL_W-1:0]         clamped;
    logic [UVAL_W-1:0]         light_next;
    logic [VALUE_W-1:0]        temp_next;
    logic [UVAL_W-1:0]         hum_next;

    assign is_report = (r_in_kind == KIND_REPORT);
    // Samples always move on; a report needs room in the result register.
    assign advance   = r_in_valid && (!is_report || !r_out_valid || i_out_ready);
    assign load_out  = advance && is_report;
    assign o_in_ready = !r_in_valid || advance;

    assign clamped = f_clamp_u10(r_in_value);

    assign ctrl_light.push  = advance && (r_in_kind == KIND_LIGHT);
    assign ctrl_light.latch = load_out;
    assign ctrl_temp.push   = advance && (r_in_kind == KIND_TEMP) && r_in_ok;
    assign ctrl_temp.latch  = load_out;
    assign ctrl_hum.push    = advance && (r_in_kind == KIND_HUM) && r_in_ok;
    assign ctrl_hum.latch   = load_out;

    swae_channel #(
        .WINDOW      (WINDOW),
        .DATA_W      (UVAL_W),
        .SIGNED_DATA (1'b0)
    ) u_light (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl_light),
        .i_value     (clamped),
        .o_held_next (light_next)
    );

    swae_channel #(
        .WINDOW      (WINDOW),
        .DATA_W      (VALUE_W),
        .SIGNED_DATA (1'b1)
    ) u_temp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl_temp),
        .i_value     (r_in_value),
        .o_held_next (temp_next)
    );

    swae_channel #(
        .WINDOW      (WINDOW),
        .DATA_W      (UVAL_W),
        .SIGNED_DATA (1'b0)
    ) u_hum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl_hum),
        .i_value     (clamped),
        .o_held_next (hum_next)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_kind  <= i_kind;
            r_in_value <= i_sample_value;
            r_in_ok    <= i_sample_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_temp_limit  <= TEMP_LIMIT_RST;
            r_hum_limit   <= HUM_LIMIT_RST;
            r_light_limit <= LIGHT_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TEMP_LIMIT:  r_temp_limit  <= i_cfg_data;
                CFG_HUM_LIMIT:   r_hum_limit   <= i_cfg_data[UVAL_W-1:0];
                CFG_LIGHT_LIMIT: r_light_limit <= i_cfg_data[UVAL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_event     <= f_event(signed'(temp_next), hum_next, light_next,
                                   r_temp_limit, r_hum_limit, r_light_limit);
            r_temp_avg  <= temp_next;
            r_hum_avg   <= hum_next;
            r_light_avg <= light_next;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_event_code       = r_event;
    assign o_temp_average     = r_temp_avg;
    assign o_humidity_average = r_hum_avg;
    assign o_light_average    = r_light_avg;

    // A new result only ever comes from a report that sat in the input register.
    a_result_from_report: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_in_valid && (r_in_kind == KIND_REPORT)))
        else $error("result appeared without a report");

    // A report blocked by a full result register must stay in the input register.
    a_report_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && is_report && r_out_valid && !i_out_ready)
        |=> (r_in_valid && is_report))
        else $error("blocked report was lost");

    // Sample transactions never stall the input side.
    a_sample_flows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !is_report) |-> o_in_ready)
        else $error("sample stalled the input");

endmodule

@@ hw/rtl/swae_channel.sv @@
// One sensor channel: sample ring, new-sample count, registered window sum and held average.
module swae_channel #(
    parameter int WINDOW      = 4,
    parameter int DATA_W      = 10,
    parameter bit SIGNED_DATA = 1'b0
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  swae_pkg::t_chan_ctrl   i_ctrl,
    input  logic [DATA_W-1:0]      i_value,
    output logic [DATA_W-1:0]      o_held_next
);
    import swae_pkg::*;

    localparam int POS_W  = $clog2(WINDOW);
    localparam int CNT_W  = $clog2(WINDOW + 1);
    localparam int LOG_W  = $clog2(WINDOW);
    localparam int SUM_W  = VALUE_W + LOG_W;
    localparam int LEAVES = 2 ** LOG_W;
    // Floor division by WINDOW as a multiply by a rounded-up reciprocal.
    localparam int SHIFT  = SUM_W + LOG_W;
    localparam int RCP_W  = SUM_W + 1;
    localparam int PROD_W = SUM_W + RCP_W;
    localparam longint unsigned RCP_VAL =
        ((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
    localparam logic [RCP_W-1:0] RECIP  = RCP_W'(RCP_VAL);
    // Bias that makes every possible sum non-negative.
    localparam logic [SUM_W-1:0] OFFSET = SUM_W'(WINDOW) << (VALUE_W - 1);

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WINDOW);

    function automatic logic signed [VALUE_W-1:0] f_ext(logic [DATA_W-1:0] v);
        logic signed [VALUE_W-1:0] res;
        if (SIGNED_DATA) begin
            res = VALUE_W'(signed'(v));
        end else begin
            res = VALUE_W'(v);
        end
        return res;
    endfunction

    logic [DATA_W-1:0] r_ring [WINDOW];
    logic [DATA_W-1:0] n_ring [WINDOW];
    logic [POS_W-1:0]  r_pos;
    logic [POS_W-1:0]  n_pos;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;
    logic signed [SUM_W-1:0] r_sum;
    logic [DATA_W-1:0] r_held;
    logic [DATA_W-1:0] n_held;

    logic signed [SUM_W-1:0] tree [1:2*LEAVES-1];
    logic [SUM_W-1:0]        biased;
    logic [PROD_W-1:0]       product;
    logic [VALUE_W-1:0]      quot;
    logic [VALUE_W-1:0]      avg;
    logic                    full;

    always_comb begin
        for (int k = 0; k < WINDOW; k++) begin
            n_ring[k] = r_ring[k];
        end
        n_pos = r_pos;
        if (i_ctrl.push) begin
            n_ring[r_pos] = i_value;
            n_pos = (r_pos == POS_LAST) ? '0 : r_pos + POS_W'(1);
        end
    end

    // The sum is taken over the ring as it will be after this cycle, so it
    // is current when a report follows a sample directly.
    for (genvar g = 0; g < LEAVES; g++) begin : g_leaf
        if (g < WINDOW) begin : g_used
            assign tree[LEAVES + g] = SUM_W'(f_ext(n_ring[g]));
        end else begin : g_pad
            assign tree[LEAVES + g] = '0;
        end
    end
    for (genvar g = 1; g < LEAVES; g++) begin : g_node
        assign tree[g] = tree[2 * g] + tree[2 * g + 1];
    end

    assign full    = (r_count == CNT_FULL);
    assign biased  = unsigned'(r_sum) + OFFSET;
    assign product = PROD_W'(biased) * PROD_W'(RECIP);
    assign quot    = product[SHIFT +: VALUE_W];
    // Removing the bias is a flip of the top bit.
    assign avg     = {~quot[VALUE_W-1], quot[VALUE_W-2:0]};

    always_comb begin
        n_count = r_count;
        n_held  = r_held;
        if (i_ctrl.push && !full) begin
            n_count = r_count + CNT_W'(1);
        end
        if (i_ctrl.latch && full) begin
            n_count = '0;
            n_held  = avg[DATA_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_count <= '0;
            r_held  <= '0;
        end else begin
            r_pos   <= n_pos;
            r_count <= n_count;
            r_held  <= n_held;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < WINDOW; k++) begin
            r_ring[k] <= n_ring[k];
        end
        r_sum <= tree[1];
    end

    assign o_held_next = n_held;

endmodule
